FILE: rtl/ffta_pkg.sv
// Shared types and constants for the first-fit tagged allocator.
package ffta_pkg;

    localparam int MAX_UNITS_DEF  = 256;
    localparam int OWNER_BITS_DEF = 16;

    localparam int UNITS_W  = 9;
    localparam int LEN_W    = 9;
    localparam int OWNER_W  = 16;
    localparam int START_W  = 8;
    localparam int FREED_W  = 9;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [UNITS_W-1:0] UNITS_RESET = 9'd256;

    // register index decoded from paddr[2]
    localparam logic REG_UNITS_IN_USE = 1'b0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAG,
        ST_FREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               status;
        logic [START_W-1:0] start_index;
        logic [FREED_W-1:0] freed_count;
    } result_t;

endpackage

FILE: rtl/first_fit_tagged_allocator.sv
// Top level of the first-fit tagged allocator: config register, cell chain, sequencer.
// Usage:
//  - Request channel (req_valid / req_stall): command 0 allocates run_length
//    consecutive free units for owner_id, command 1 frees every unit tagged
//    with owner_id. A request is taken when req_valid is high and req_stall
//    is low; req_stall stays high while a request is being worked on.
//  - Result channel (res_valid / res_stall): one result per request with
//    status (0 ok, 1 no run found), start_index and freed_count.
//  - The owner map is a ring of MAX_UNITS tag cells that rotates one unit
//    per cycle past the sequencer at its head while it scans, tags or
//    frees; a full rotation restores order. Free and failed allocate make
//    one rotation before the result; a successful allocate makes two
//    (one rotation to find the run, one to tag it). One request is in flight
//    at a time, so a new request is not taken until the result of the
//    previous one has been written to the output register.
//  - A finished result sits in an output register. If the receiver stalls,
//    a following request still runs; its result waits until the register
//    frees up.
//  - Reset clears every tag (all units free), sets units_in_use to 256 and
//    empties the result register. units_in_use (APB address 0) should be
//    written only while the block is idle.
module first_fit_tagged_allocator
    import ffta_pkg::*;
#(
    parameter int MAX_UNITS  = MAX_UNITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                command,
    input  logic [LEN_W-1:0]    run_length,
    input  logic [OWNER_W-1:0]  owner_id,
    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output logic                status,
    output logic [START_W-1:0]  start_index,
    output logic [FREED_W-1:0]  freed_count
);

    logic [UNITS_W-1:0] units_reg;
    logic               cfg_write;

    logic [OWNER_BITS-1:0] tag_q [MAX_UNITS];
    logic                  shift;
    logic [OWNER_BITS-1:0] tail;
    result_t               res;

    // APB: word-aligned, register index taken from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_UNITS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= UNITS_RESET;
        end
        else if (cfg_write)
        begin
            units_reg <= pwdata[UNITS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_UNITS_IN_USE) ? DATA_W'(units_reg) : '0;

    // Tag ring: cell i loads from cell i+1, the last cell from the sequencer.
    for (genvar i = 0; i < MAX_UNITS; i++)
    begin : g_cell
        logic [OWNER_BITS-1:0] d;
        if (i == MAX_UNITS - 1)
        begin : g_tail
            assign d = tail;
        end
        else
        begin : g_link
            assign d = tag_q[i+1];
        end

        ffta_cell #(
            .OWNER_BITS (OWNER_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (d),
            .q     (tag_q[i])
        );
    end

    ffta_ctrl #(
        .MAX_UNITS  (MAX_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .run_length (run_length),
        .owner_id   (owner_id),
        .units      (units_reg),
        .head       (tag_q[0]),
        .shift      (shift),
        .tail       (tail),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    assign status      = res.status;
    assign start_index = res.start_index;
    assign freed_count = res.freed_count;

endmodule

FILE: rtl/ffta_cell.sv
// One unit of the owner map: a tag register in the rotating chain.
module ffta_cell
    import ffta_pkg::*;
#(
    parameter int OWNER_BITS = OWNER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  logic [OWNER_BITS-1:0] d,
    output logic [OWNER_BITS-1:0] q
);

    logic [OWNER_BITS-1:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (shift)
        begin
            tag_reg <= d;
        end
    end

    assign q = tag_reg;

endmodule

FILE: rtl/ffta_ctrl.sv
// Sequencer at the head of the chain: scans, tags and frees one unit per cycle.
module ffta_ctrl
    import ffta_pkg::*;
#(
    parameter int MAX_UNITS  = MAX_UNITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  command,
    input  logic [LEN_W-1:0]      run_length,
    input  logic [OWNER_W-1:0]    owner_id,
    input  logic [UNITS_W-1:0]    units,
    input  logic [OWNER_BITS-1:0] head,
    output logic                  shift,
    output logic [OWNER_BITS-1:0] tail,
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res
);

    localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_UNITS - 1);
    localparam logic [CMP_W-1:0] MAX_N    = CMP_W'(MAX_UNITS);

    state_t                state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [CMP_W-1:0]      len_reg, len_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      first_reg, first_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      freed_reg, freed_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic [CMP_W-1:0] units_ext;
    logic [CMP_W-1:0] n_active;
    logic             active;
    logic [CMP_W-1:0] count_inc;
    logic [CMP_W:0]   run_end;
    logic             in_run;
    logic             owner_nz;

    assign units_ext = CMP_W'(units);
    assign n_active  = (units_ext > MAX_N) ? MAX_N : units_ext;
    assign active    = CMP_W'(idx_reg) < n_active;
    assign count_inc = CMP_W'(count_reg) + CMP_W'(1);
    assign run_end   = (CMP_W + 1)'(first_reg) + (CMP_W + 1)'(len_reg);
    assign in_run    = (idx_reg >= first_reg) && ((CMP_W + 1)'(idx_reg) < run_end);
    assign owner_nz  = (owner_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_ALLOC;
            len_reg       <= '0;
            owner_reg     <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            found_reg     <= 1'b0;
            freed_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            owner_reg     <= owner_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            freed_reg     <= freed_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        owner_next     = owner_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        freed_next     = freed_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        shift          = 1'b0;
        tail           = head;

        // result taken by the receiver
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = command;
                    len_next   = CMP_W'(run_length);
                    owner_next = OWNER_BITS'(owner_id);
                    idx_next   = '0;
                    count_next = '0;
                    first_next = '0;
                    found_next = 1'b0;
                    freed_next = '0;
                    state_next = (command == CMD_FREE) ? ST_FREE : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // first pass: find the run, tags pass through unchanged
                shift    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (!found_reg && active)
                begin
                    if (head != '0)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            first_next = idx_reg;
                        end
                        count_next = count_reg + CNT_W'(1);
                        if (count_inc == len_reg && owner_nz)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = found_next ? ST_TAG : ST_DONE;
                end
            end

            ST_TAG:
            begin
                shift    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (in_run)
                begin
                    tail = owner_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_FREE:
            begin
                shift    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (active && owner_nz && head == owner_reg)
                begin
                    tail       = '0;
                    freed_next = freed_reg + CNT_W'(1);
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        res_next.status      = found_reg ? STATUS_OK : STATUS_FAIL;
                        res_next.start_index = found_reg ? START_W'(first_reg) : '0;
                        res_next.freed_count = '0;
                    end
                    else
                    begin
                        res_next.status      = STATUS_OK;
                        res_next.start_index = '0;
                        res_next.freed_count = FREED_W'(freed_reg);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
